// File: design/rviexu_pkg.sv
// Shared types and constants for the RV32I integer execute unit.
// Depends on nothing; the front end, back end and top level refer to it by scoped names.
`timescale 1ns / 1ps
package rviexu_pkg;

   localparam int NUM_REGS = 32;
   localparam int REG_AW   = $clog2(NUM_REGS);

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
   localparam logic [1:0] STATUS_FAULT   = 2'd2;
   localparam logic [1:0] STATUS_ORDER   = 2'd3;

   // memory request codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // major opcodes
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;

   localparam logic [6:0] F7_ALT = 7'h20;

   // instruction classes produced by the front end
   localparam logic [3:0] CLS_ILLEGAL = 4'd0;
   localparam logic [3:0] CLS_LUI     = 4'd1;
   localparam logic [3:0] CLS_AUIPC   = 4'd2;
   localparam logic [3:0] CLS_JAL     = 4'd3;
   localparam logic [3:0] CLS_JALR    = 4'd4;
   localparam logic [3:0] CLS_BRANCH  = 4'd5;
   localparam logic [3:0] CLS_LOAD    = 4'd6;
   localparam logic [3:0] CLS_STORE   = 4'd7;
   localparam logic [3:0] CLS_ALU     = 4'd8;

   typedef struct packed {
      logic        op;
      logic [31:0] instruction_word;
      logic [31:0] load_data;
      logic        load_fault;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_pc;
      logic        branch_taken;
      logic [1:0]  mem_request;
      logic [31:0] mem_address;
      logic [31:0] mem_write_data;
      logic [1:0]  mem_size;
      logic        reg_write_valid;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
   } rsp_type;

   // decoded request handed from front to back
   typedef struct packed {
      logic              op;
      logic [31:0]       load_data;
      logic              load_fault;
      logic [3:0]        cls;
      logic [2:0]        f3;
      logic              alt;
      logic              use_imm;
      logic [REG_AW-1:0] rd;
      logic [REG_AW-1:0] rs1;
      logic [REG_AW-1:0] rs2;
      logic [31:0]       imm;
   } dec_type;

endpackage

// File: design/rviexu_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module rviexu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

// File: design/rviexu_front.sv
// Front end: accepts requests, decodes and classifies them, and queues them
// two deep for the back end. Depends on rviexu_pkg.
`timescale 1ns / 1ps
module rviexu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  rviexu_pkg::req_type req_data,
   output logic                q_valid,
   output rviexu_pkg::dec_type q_item,
   input  logic                q_pop
);

   rviexu_pkg::dec_type dec;
   rviexu_pkg::dec_type ent_ff [2];
   logic       head_ff, head_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, tail;

   logic [31:0] w;
   logic [6:0]  opc, f7;
   logic [2:0]  f3;

   always_comb begin
      w   = req_data.instruction_word;
      opc = w[6:0];
      f3  = w[14:12];
      f7  = w[31:25];
      dec            = '0;
      dec.op         = req_data.op;
      dec.load_data  = req_data.load_data;
      dec.load_fault = req_data.load_fault;
      dec.f3         = f3;
      dec.rd         = w[11:7];
      dec.rs1        = w[19:15];
      dec.rs2        = w[24:20];
      dec.imm        = {{20{w[31]}}, w[31:20]};
      dec.cls        = rviexu_pkg::CLS_ILLEGAL;
      unique case (opc)
         rviexu_pkg::OPC_LUI: begin
            dec.cls = rviexu_pkg::CLS_LUI;
            dec.imm = {w[31:12], 12'h000};
         end
         rviexu_pkg::OPC_AUIPC: begin
            dec.cls = rviexu_pkg::CLS_AUIPC;
            dec.imm = {w[31:12], 12'h000};
         end
         rviexu_pkg::OPC_JAL: begin
            dec.cls = rviexu_pkg::CLS_JAL;
            dec.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
         end
         rviexu_pkg::OPC_JALR: begin
            if (f3 == 3'd0) dec.cls = rviexu_pkg::CLS_JALR;
         end
         rviexu_pkg::OPC_BRANCH: begin
            if (f3 != 3'd2 && f3 != 3'd3) dec.cls = rviexu_pkg::CLS_BRANCH;
            dec.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
         end
         rviexu_pkg::OPC_LOAD: begin
            if (f3 != 3'd3 && f3 < 3'd6) dec.cls = rviexu_pkg::CLS_LOAD;
         end
         rviexu_pkg::OPC_STORE: begin
            if (f3 <= 3'd2) dec.cls = rviexu_pkg::CLS_STORE;
            dec.imm = {{20{w[31]}}, w[31:25], w[11:7]};
         end
         rviexu_pkg::OPC_OPIMM: begin
            dec.use_imm = 1'b1;
            dec.alt     = (f3 == 3'd5) && (f7 == rviexu_pkg::F7_ALT);
            if (f3 == 3'd1) begin
               if (f7 == 7'd0) dec.cls = rviexu_pkg::CLS_ALU;
            end else if (f3 == 3'd5) begin
               if (f7 == 7'd0 || f7 == rviexu_pkg::F7_ALT) dec.cls = rviexu_pkg::CLS_ALU;
            end else begin
               dec.cls = rviexu_pkg::CLS_ALU;
            end
         end
         rviexu_pkg::OPC_OP: begin
            dec.alt = (f7 == rviexu_pkg::F7_ALT);
            if (f7 == 7'd0 || (f7 == rviexu_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
               dec.cls = rviexu_pkg::CLS_ALU;
         end
         default: dec.cls = rviexu_pkg::CLS_ILLEGAL;
      endcase
   end

   assign req_full = (cnt_ff == 2'd2);
   assign push     = req_push && !req_full;
   assign tail     = head_ff ^ (cnt_ff == 2'd1);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = ent_ff[head_ff];
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   assign head_in  = head_ff ^ q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         head_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[tail] <= dec;
      end
   end

endmodule

// File: design/rviexu_back.sv
// Back end: reads the register file, executes one decoded request a cycle
// while the result queue has room, updates PC and load state, and queues
// results two deep. Depends on rviexu_pkg and rviexu_ram.
`timescale 1ns / 1ps
module rviexu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  rviexu_pkg::dec_type q_item,
   output logic                q_pop,
   input  logic                csr_write,
   input  logic [31:0]         csr_data,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output rviexu_pkg::rsp_type rsp_data
);

   localparam int AW = rviexu_pkg::REG_AW;

   rviexu_pkg::dec_type e1_ff;
   logic                e1_valid_ff, e1_valid_in;
   logic                retire, adv;

   logic [31:0] pc_ff, pc_in;
   logic        lp_ff, lp_in;
   logic [AW-1:0] pdest_ff, pdest_in;
   logic [2:0]  pkind_ff, pkind_in;

   logic [rviexu_pkg::NUM_REGS-1:0] rvalid_ff;
   logic [AW-1:0] ra_addr, rb_addr;
   logic [31:0]   ram_a, ram_b;
   logic          va_ff, vb_ff, byp_a_ff, byp_b_ff;
   logic [31:0]   byp_val_ff;

   logic          wr_en;
   logic [31:0]   a, b, opnd2, alu_out, ld_val, sum_a;
   logic          cond, exec_ok;
   rviexu_pkg::rsp_type res;

   rviexu_pkg::rsp_type out_ff [2];
   logic       ohead_ff;
   logic [1:0] ocnt_ff;
   logic       opop, otail;

   assign retire      = e1_valid_ff && (ocnt_ff != 2'd2);
   assign adv         = !e1_valid_ff || retire;
   assign q_pop       = q_valid && adv;
   assign e1_valid_in = adv ? q_valid : e1_valid_ff;

   // read the operands of whichever request sits in execute next cycle
   assign ra_addr = q_pop ? q_item.rs1 : e1_ff.rs1;
   assign rb_addr = q_pop ? q_item.rs2 : e1_ff.rs2;

   assign wr_en = retire && res.reg_write_valid;

   rviexu_ram #(.WIDTH(32), .DEPTH(rviexu_pkg::NUM_REGS)) u_regs (
      .clock   (clock),
      .we      (wr_en),
      .waddr   (res.reg_write_index),
      .wdata   (res.reg_write_value),
      .raddr_a (ra_addr),
      .raddr_b (rb_addr),
      .rdata_a (ram_a),
      .rdata_b (ram_b)
   );

   always_comb begin
      if (byp_a_ff) a = byp_val_ff;
      else a = va_ff ? ram_a : 32'd0;
      if (byp_b_ff) b = byp_val_ff;
      else b = vb_ff ? ram_b : 32'd0;
      opnd2 = e1_ff.use_imm ? e1_ff.imm : b;
      sum_a = a + e1_ff.imm;
   end

   always_comb begin
      unique case (e1_ff.f3)
         3'd0: alu_out = e1_ff.alt ? a - opnd2 : a + opnd2;
         3'd1: alu_out = a << opnd2[4:0];
         3'd2: alu_out = {31'd0, $signed(a) < $signed(opnd2)};
         3'd3: alu_out = {31'd0, a < opnd2};
         3'd4: alu_out = a ^ opnd2;
         3'd5: alu_out = e1_ff.alt ? $unsigned($signed(a) >>> opnd2[4:0])
                                   : a >> opnd2[4:0];
         3'd6: alu_out = a | opnd2;
         default: alu_out = a & opnd2;
      endcase
      unique case (e1_ff.f3)
         3'd0: cond = (a == b);
         3'd1: cond = (a != b);
         3'd4: cond = $signed(a) < $signed(b);
         3'd5: cond = !($signed(a) < $signed(b));
         3'd6: cond = (a < b);
         default: cond = (a >= b);
      endcase
      unique case (pkind_ff)
         3'd0: ld_val = {{24{e1_ff.load_data[7]}}, e1_ff.load_data[7:0]};
         3'd1: ld_val = {{16{e1_ff.load_data[15]}}, e1_ff.load_data[15:0]};
         3'd4: ld_val = {24'd0, e1_ff.load_data[7:0]};
         3'd5: ld_val = {16'd0, e1_ff.load_data[15:0]};
         default: ld_val = e1_ff.load_data;
      endcase
   end

   always_comb begin
      res         = '0;
      res.next_pc = pc_ff;
      exec_ok     = 1'b0;
      lp_in       = lp_ff;
      pdest_in    = pdest_ff;
      pkind_in    = pkind_ff;
      if (e1_ff.op) begin
         if (!lp_ff) begin
            res.status = rviexu_pkg::STATUS_ORDER;
         end else begin
            lp_in = 1'b0;
            if (e1_ff.load_fault) begin
               res.status = rviexu_pkg::STATUS_FAULT;
            end else if (pdest_ff != '0) begin
               res.reg_write_valid = 1'b1;
               res.reg_write_index = pdest_ff;
               res.reg_write_value = ld_val;
            end
         end
      end else if (lp_ff) begin
         res.status = rviexu_pkg::STATUS_ORDER;
      end else if (e1_ff.cls == rviexu_pkg::CLS_ILLEGAL) begin
         res.status = rviexu_pkg::STATUS_ILLEGAL;
      end else begin
         exec_ok     = 1'b1;
         res.next_pc = pc_ff + 32'd4;
         res.reg_write_index = e1_ff.rd;
         unique case (e1_ff.cls)
            rviexu_pkg::CLS_LUI:   res.reg_write_value = e1_ff.imm;
            rviexu_pkg::CLS_AUIPC: res.reg_write_value = pc_ff + e1_ff.imm;
            rviexu_pkg::CLS_JAL: begin
               res.reg_write_value = pc_ff + 32'd4;
               res.next_pc         = pc_ff + e1_ff.imm;
               res.branch_taken    = 1'b1;
            end
            rviexu_pkg::CLS_JALR: begin
               res.reg_write_value = pc_ff + 32'd4;
               res.next_pc         = {sum_a[31:1], 1'b0};
               res.branch_taken    = 1'b1;
            end
            rviexu_pkg::CLS_BRANCH: begin
               if (cond) begin
                  res.next_pc      = pc_ff + e1_ff.imm;
                  res.branch_taken = 1'b1;
               end
            end
            rviexu_pkg::CLS_LOAD: begin
               res.mem_request = rviexu_pkg::MEM_READ;
               res.mem_address = sum_a;
               res.mem_size    = {1'b0, e1_ff.f3[1:0]} == 3'd3 ? 2'd0 : e1_ff.f3[1:0];
               lp_in    = 1'b1;
               pdest_in = e1_ff.rd;
               pkind_in = e1_ff.f3;
            end
            rviexu_pkg::CLS_STORE: begin
               res.mem_request = rviexu_pkg::MEM_WRITE;
               res.mem_address = sum_a;
               res.mem_size    = e1_ff.f3[1:0];
               unique case (e1_ff.f3[1:0])
                  2'd0: res.mem_write_data = {24'd0, b[7:0]};
                  2'd1: res.mem_write_data = {16'd0, b[15:0]};
                  default: res.mem_write_data = b;
               endcase
            end
            default: res.reg_write_value = alu_out;
         endcase
         // only register-writing classes keep the destination fields
         if (e1_ff.cls == rviexu_pkg::CLS_BRANCH || e1_ff.cls == rviexu_pkg::CLS_LOAD ||
             e1_ff.cls == rviexu_pkg::CLS_STORE || e1_ff.rd == '0) begin
            res.reg_write_index = '0;
            res.reg_write_value = '0;
         end else begin
            res.reg_write_valid = 1'b1;
         end
      end
   end

   always_comb begin
      if (csr_write) pc_in = csr_data;
      else if (retire && exec_ok) pc_in = res.next_pc;
      else pc_in = pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         pc_ff       <= 32'd0;
         lp_ff       <= 1'b0;
         pdest_ff    <= '0;
         pkind_ff    <= 3'd0;
         rvalid_ff   <= '0;
         byp_a_ff    <= 1'b0;
         byp_b_ff    <= 1'b0;
         ocnt_ff     <= 2'd0;
         ohead_ff    <= 1'b0;
      end else begin
         e1_valid_ff <= e1_valid_in;
         pc_ff       <= pc_in;
         if (retire) begin
            lp_ff    <= lp_in;
            pdest_ff <= pdest_in;
            pkind_ff <= pkind_in;
         end
         if (wr_en) rvalid_ff[res.reg_write_index] <= 1'b1;
         // forward a write that lands in the same cycle as the read
         byp_a_ff <= wr_en && (res.reg_write_index == ra_addr);
         byp_b_ff <= wr_en && (res.reg_write_index == rb_addr);
         ocnt_ff  <= ocnt_ff + {1'b0, retire} - {1'b0, opop};
         ohead_ff <= ohead_ff ^ opop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) e1_ff <= q_item;
      va_ff      <= rvalid_ff[ra_addr];
      vb_ff      <= rvalid_ff[rb_addr];
      byp_val_ff <= res.reg_write_value;
      if (retire) out_ff[otail] <= res;
   end

   assign otail     = ohead_ff ^ (ocnt_ff == 2'd1);
   assign opop      = rsp_pop && (ocnt_ff != 2'd0);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_data  = out_ff[ohead_ff];

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> res.reg_write_index != '0)
      else $error("write to x0 issued");

   a_load_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (retire && res.mem_request == rviexu_pkg::MEM_READ) |=> lp_ff)
      else $error("load issued without pending state");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff != 2'd3)
      else $error("result queue overflow");

   a_pc_holds_on_illegal: assert property (@(posedge clock) disable iff (reset)
      (retire && res.status == rviexu_pkg::STATUS_ILLEGAL && !csr_write)
      |=> $stable(pc_ff))
      else $error("PC moved on illegal instruction");

endmodule

// File: design/rv32i_integer_execute_unit_top.sv
// Top level of the RV32I integer execute unit.
// Depends on rviexu_pkg, rviexu_front and rviexu_back.
`timescale 1ns / 1ps
// Queue-style requests in, queue-style results out, one result per request.
// A request is taken each cycle while req_full is low; it passes through the
// decode queue, then register file read, then execute. The throughput is one
// request per cycle while neither queue is full, set by the single execute
// stage and the two-read-port register file. Writing csr_data loads the PC
// at once; register file entries read as zero until first written.
module rv32i_integer_execute_unit_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  rviexu_pkg::req_type req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rviexu_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_data
);

   logic                q_valid, q_pop;
   rviexu_pkg::dec_type q_item;

   assign csr_ready = 1'b1;

   rviexu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   rviexu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule
